### rtl/tbrl_pkg.sv
// Shared types and constants of the token bucket rate limiter.
// Used by every module of the block; depends on nothing.
package tbrl_pkg;

  localparam int unsigned TimeBits = 48;

  // One token is kept as one million micro-tokens.
  localparam logic [35:0] Micro36 = 36'd1000000;

  // An elapsed time of 2^36 us or more fills the bucket, unless the rate is zero or the disk is critical.
  localparam logic [63:0] ElSatLimit = 64'h10_0000_0000;

  localparam logic [62:0] Max63 = '1;
  localparam logic [47:0] Max48 = '1;
  localparam logic [31:0] Max32 = '1;

  // Reciprocal of 1000 for inputs below 2^42: q = (x * DivMul) >> DivShift.
  localparam int unsigned DivShift = 52;
  localparam logic [42:0] DivMul = 43'((64'd1 << DivShift) / 64'd1000 + 64'd1);
  // At and above this many microseconds the millisecond count saturates.
  localparam logic [47:0] MsSatLimit = 48'd4294967296000;

  localparam logic [19:0] ResetRate     = 20'd100;
  localparam logic [35:0] ResetCap      = 36'd16000000;
  localparam logic [31:0] ResetInterval = 32'd60000000;

  typedef enum logic [1:0] {
    RegEnable   = 2'd0,
    RegRate     = 2'd1,
    RegBurst    = 2'd2,
    RegInterval = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CmdTry      = 2'd0,
    CmdFirst    = 2'd1,
    CmdRetry    = 2'd2,
    CmdTryAlias = 2'd3
  } cmd_e;

  typedef struct packed {
    logic        enable;
    logic [19:0] rate;
    logic [35:0] cap;
    logic [31:0] interval;
    logic        reload;
    logic [35:0] reload_level;
  } cfg_t;

  typedef struct packed {
    logic        granted;
    logic [35:0] tokens_level;
    logic [63:0] acquired;
    logic [63:0] blocked;
    logic [62:0] wait_total;
    logic        fire;
    logic [31:0] ev_blk_cnt;
    logic [47:0] ev_wait_us;
  } res_t;

endpackage

### rtl/tbrl_cfg.sv
// Configuration registers of the rate limiter and the bucket reload request.
// Depends on tbrl_pkg.
module tbrl_cfg import tbrl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  logic        enable_q, enable_d;
  logic [19:0] rate_q, rate_d;
  logic [35:0] cap_q, cap_d;
  logic [31:0] interval_q, interval_d;
  logic [35:0] burst_cap;
  cfg_reg_e    idx;

  assign idx       = cfg_reg_e'(cfg_idx_i);
  assign burst_cap = 36'(cfg_wdata_i[15:0]) * Micro36;

  always_comb begin
    enable_d   = enable_q;
    rate_d     = rate_q;
    cap_d      = cap_q;
    interval_d = interval_q;
    if (cfg_we_i) begin
      unique case (idx)
        RegEnable:   enable_d   = cfg_wdata_i[0];
        RegRate:     rate_d     = cfg_wdata_i[19:0];
        RegBurst:    cap_d      = burst_cap;
        RegInterval: interval_d = cfg_wdata_i;
        default:     enable_d   = enable_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= 1'b0;
      rate_q     <= ResetRate;
      cap_q      <= ResetCap;
      interval_q <= ResetInterval;
    end else begin
      enable_q   <= enable_d;
      rate_q     <= rate_d;
      cap_q      <= cap_d;
      interval_q <= interval_d;
    end
  end

  // Writing enable or burst refills the bucket to the (new) capacity.
  always_comb begin
    cfg_o.enable       = enable_q;
    cfg_o.rate         = rate_q;
    cfg_o.cap          = cap_q;
    cfg_o.interval     = interval_q;
    cfg_o.reload       = cfg_we_i && (idx == RegEnable || idx == RegBurst);
    cfg_o.reload_level = (idx == RegBurst) ? burst_cap : cap_q;
  end

endmodule

### rtl/tbrl_update.sv
// Bucket, timestamp and statistics state and its per-item update.
// Depends on tbrl_pkg; configuration arrives from tbrl_cfg.
module tbrl_update import tbrl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                step_i,
  input  logic [1:0]          cmd_i,
  input  logic [TimeBits-1:0] now_i,
  input  logic                crit_i,
  output res_t                res_o
);

  logic [35:0]         bucket_q, bucket_d;
  logic [TimeBits-1:0] last_refill_q, last_refill_d;
  logic [TimeBits-1:0] wait_start_q, wait_start_d;
  logic [63:0]         acq_q, acq_d;
  logic [63:0]         blk_q, blk_d;
  logic [62:0]         tw_q, tw_d;
  logic [TimeBits-1:0] last_ev_q, last_ev_d;
  logic                seen_q, seen_d;
  logic [31:0]         bse_q, bse_d;
  logic [47:0]         wse_q, wse_d;

  logic [TimeBits-1:0] el, waited, ev_el;
  logic [55:0]         prod;
  logic [56:0]         fill_sum;
  logic [35:0]         refill, lvl_new;
  logic                grant, retry_grant, ev_ok, fire;
  logic [64:0]         tw_sum, ws_sum;
  logic [62:0]         tw_sat;
  logic [47:0]         wse_new;
  logic [31:0]         bse_inc;
  logic                en;
  cmd_e                cmd;

  assign en  = cfg_i.enable;
  assign cmd = cmd_e'(cmd_i);

  always_comb begin
    el       = (now_i > last_refill_q) ? now_i - last_refill_q : '0;
    prod     = 56'(cfg_i.rate) * 56'(36'(el));
    fill_sum = 57'(bucket_q) + 57'(prod);
    if (crit_i) begin
      refill = '0;
    end else if (cfg_i.rate == '0) begin
      refill = bucket_q;
    end else if (64'(el) >= ElSatLimit) begin
      refill = cfg_i.cap;
    end else if (fill_sum > 57'(cfg_i.cap)) begin
      refill = cfg_i.cap;
    end else begin
      refill = 36'(fill_sum);
    end
    grant   = refill >= Micro36;
    lvl_new = grant ? refill - Micro36 : refill;

    // Statistics of a blocking retry that got its token.
    waited  = (now_i > wait_start_q) ? now_i - wait_start_q : '0;
    tw_sum  = 65'(tw_q) + 65'(waited);
    tw_sat  = (tw_sum > 65'(Max63)) ? Max63 : 63'(tw_sum);
    ws_sum  = 65'(wse_q) + 65'(waited);
    wse_new = (ws_sum > 65'(Max48)) ? Max48 : 48'(ws_sum);
    bse_inc = (bse_q != Max32) ? bse_q + 32'd1 : bse_q;
    ev_el   = (now_i > last_ev_q) ? now_i - last_ev_q : '0;
    ev_ok   = !seen_q || (64'(ev_el) >= 64'(cfg_i.interval));

    retry_grant = en && grant && (cmd == CmdRetry);
    fire        = retry_grant && ev_ok;
  end

  always_comb begin
    res_o.granted      = !en || grant;
    res_o.tokens_level = en ? lvl_new : bucket_q;
    res_o.acquired     = (en && grant) ? acq_q + 64'd1 : acq_q;
    res_o.blocked      = retry_grant ? blk_q + 64'd1 : blk_q;
    res_o.wait_total   = retry_grant ? tw_sat : tw_q;
    res_o.fire         = fire;
    res_o.ev_blk_cnt   = fire ? bse_inc : '0;
    res_o.ev_wait_us   = fire ? wse_new : '0;
  end

  always_comb begin
    bucket_d      = bucket_q;
    last_refill_d = last_refill_q;
    wait_start_d  = wait_start_q;
    acq_d         = acq_q;
    blk_d         = blk_q;
    tw_d          = tw_q;
    last_ev_d     = last_ev_q;
    seen_d        = seen_q;
    bse_d         = bse_q;
    wse_d         = wse_q;
    if (cfg_i.reload) begin
      bucket_d = cfg_i.reload_level;
    end else if (step_i && en) begin
      bucket_d      = lvl_new;
      last_refill_d = now_i;
      acq_d         = res_o.acquired;
      blk_d         = res_o.blocked;
      tw_d          = res_o.wait_total;
      if (!grant && cmd == CmdFirst) begin
        wait_start_d = now_i;
      end
      if (fire) begin
        last_ev_d = now_i;
        seen_d    = 1'b1;
        bse_d     = '0;
        wse_d     = '0;
      end else if (retry_grant) begin
        bse_d = bse_inc;
        wse_d = wse_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bucket_q      <= ResetCap;
      last_refill_q <= '0;
      wait_start_q  <= '0;
      acq_q         <= '0;
      blk_q         <= '0;
      tw_q          <= '0;
      last_ev_q     <= '0;
      seen_q        <= 1'b0;
      bse_q         <= '0;
      wse_q         <= '0;
    end else begin
      bucket_q      <= bucket_d;
      last_refill_q <= last_refill_d;
      wait_start_q  <= wait_start_d;
      acq_q         <= acq_d;
      blk_q         <= blk_d;
      tw_q          <= tw_d;
      last_ev_q     <= last_ev_d;
      seen_q        <= seen_d;
      bse_q         <= bse_d;
      wse_q         <= wse_d;
    end
  end

  // The bucket never holds more than its capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) bucket_q <= cfg_i.cap)
    else $error("bucket level above capacity");

  // An event is only raised by a granted blocking retry.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.fire |-> (res_o.granted && en && cmd == CmdRetry))
    else $error("event without granted retry");

  // A refused item leaves the grant counter alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !res_o.granted && !cfg_i.reload) |=> $stable(acq_q))
    else $error("grant counter moved on a refused item");

endmodule

### rtl/tbrl_ms_div.sv
// Two-stage division of the event waiting time by 1000, saturating at 32 bits.
// Depends on tbrl_pkg for the reciprocal constant.
module tbrl_ms_div import tbrl_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [47:0] us_i,
  output logic [31:0] ms_o
);

  logic        sat_q;
  logic [42:0] hh_q, lh_q;
  logic [41:0] hl_q, ll_q;
  logic [31:0] ms_q;
  logic [20:0] xh, xl;
  logic [21:0] mh;
  logic [20:0] ml;
  logic [85:0] prod_sum;

  assign xh = us_i[41:21];
  assign xl = us_i[20:0];
  assign mh = DivMul[42:21];
  assign ml = DivMul[20:0];

  // First stage: four narrow partial products of x times the reciprocal.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sat_q <= us_i >= MsSatLimit;
      hh_q  <= 43'(xh) * 43'(mh);
      hl_q  <= 42'(xh) * 42'(ml);
      lh_q  <= 43'(xl) * 43'(mh);
      ll_q  <= 42'(xl) * 42'(ml);
    end
  end

  assign prod_sum = (86'(hh_q) << 42) + ((86'(hl_q) + 86'(lh_q)) << 21) + 86'(ll_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ms_q <= sat_q ? Max32 : prod_sum[DivShift +: 32];
    end
  end

  assign ms_o = ms_q;

endmodule

### rtl/token_bucket_rate_limiter_core.sv
// Top level of the token bucket rate limiter: input register, state update,
// result pipeline and event millisecond divider. Depends on tbrl_pkg and submodules.
//
// Each input item is one token acquire attempt and yields exactly one result
// item. The block takes one item per clock cycle for as long as the output is
// not stalled; each result passes the input register, the bucket update and
// the result registers, and the two-stage divide that turns the event waiting
// time into milliseconds. An output stall holds the whole pipeline, so the
// input stalls in the same cycle. The bucket update, refill multiply and
// statistics are combinational on the registered state, so an item sees
// every state change of the item before it. There is no clearing pass after
// reset. Configuration writes take effect at once and are meant for an idle
// block; writing enable or burst refills the bucket to full.
module token_bucket_rate_limiter_core import tbrl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          command_i,
  input  logic [TimeBits-1:0] now_us_i,
  input  logic                disk_critical_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                granted_o,
  output logic [35:0]         tokens_level_o,
  output logic [63:0]         acquired_total_o,
  output logic [63:0]         blocked_total_o,
  output logic [62:0]         wait_total_us_o,
  output logic                event_fire_o,
  output logic [31:0]         event_blocked_o,
  output logic [31:0]         event_wait_ms_o
);

  cfg_t                cfg;
  res_t                res;
  logic                move;
  logic                in_valid_q, a_valid_q, b_valid_q, out_valid_q;
  logic [1:0]          cmd_q;
  logic [TimeBits-1:0] now_q;
  logic                crit_q;
  res_t                a_res_q, b_res_q, c_res_q;
  logic [31:0]         ms;

  // The pipeline moves as a whole unless a result is waiting and stalled.
  assign move       = !(out_valid_q && out_stall_i);
  assign in_stall_o = !move;

  tbrl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  tbrl_update u_update (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (move && in_valid_q),
    .cmd_i  (cmd_q),
    .now_i  (now_q),
    .crit_i (crit_q),
    .res_o  (res)
  );

  tbrl_ms_div u_ms_div (
    .clk_i (clk_i),
    .en_i  (move),
    .us_i  (a_res_q.ev_wait_us),
    .ms_o  (ms)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (move) begin
      in_valid_q  <= in_valid_i;
      a_valid_q   <= in_valid_q;
      b_valid_q   <= a_valid_q;
      out_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      cmd_q   <= command_i;
      now_q   <= now_us_i;
      crit_q  <= disk_critical_i;
      a_res_q <= res;
      b_res_q <= a_res_q;
      c_res_q <= b_res_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign granted_o        = c_res_q.granted;
  assign tokens_level_o   = c_res_q.tokens_level;
  assign acquired_total_o = c_res_q.acquired;
  assign blocked_total_o  = c_res_q.blocked;
  assign wait_total_us_o  = c_res_q.wait_total;
  assign event_fire_o     = c_res_q.fire;
  assign event_blocked_o  = c_res_q.ev_blk_cnt;
  assign event_wait_ms_o  = ms;

  // Event fields stay zero on items that raise no event, across the divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !event_fire_o) |-> (event_wait_ms_o == '0 && event_blocked_o == '0))
    else $error("event fields set without an event");

  // A held result keeps the pipeline frozen; checked on the a and b stage valid bits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> ($stable(a_valid_q) && $stable(b_valid_q)))
    else $error("pipeline advanced under output stall");

  // An event always reports at least one blocked grant.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_fire_o) |-> (event_blocked_o != '0))
    else $error("event with no blocked grants");

endmodule

### bench/tb_token_bucket_rate_limiter_core.sv
`timescale 1ns / 1ps
// Self-checking testbench of token_bucket_rate_limiter_core: directed and random
// acquire attempts checked against a bucket predictor. Depends on tbrl_pkg and the RTL.
module tb_token_bucket_rate_limiter_core;
  import tbrl_pkg::*;

  localparam logic [63:0] MicroTokens    = 64'd1000000;
  localparam logic [63:0] FillElapse     = 64'h10_0000_0000;
  localparam logic [63:0] WaitSumMax     = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] WaitWindowMax  = 64'h0000_FFFF_FFFF_FFFF;
  localparam logic [63:0] MsMax          = 64'h0000_0000_FFFF_FFFF;
  localparam logic [47:0] LastStamp      = 48'hFFFF_FFFF_FFFF;
  localparam int unsigned WatchdogLimit  = 2000;
  localparam int unsigned ItemsPerPhase  = 70;

  typedef struct packed {
    logic        granted;
    logic [35:0] tokens_level;
    logic [63:0] acquired_total;
    logic [63:0] blocked_total;
    logic [62:0] wait_total_us;
    logic        event_fire;
    logic [31:0] event_blocked;
    logic [31:0] event_wait_ms;
  } attempt_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = RegEnable;
  logic [31:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  command_i = CmdTry;
  logic [47:0] now_us_i = '0;
  logic        disk_critical_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        granted_o;
  logic [35:0] tokens_level_o;
  logic [63:0] acquired_total_o;
  logic [63:0] blocked_total_o;
  logic [62:0] wait_total_us_o;
  logic        event_fire_o;
  logic [31:0] event_blocked_o;
  logic [31:0] event_wait_ms_o;

  token_bucket_rate_limiter_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_o, .command_i, .now_us_i, .disk_critical_i,
    .out_valid_o, .out_stall_i, .granted_o, .tokens_level_o, .acquired_total_o,
    .blocked_total_o, .wait_total_us_o, .event_fire_o, .event_blocked_o,
    .event_wait_ms_o
  );

  always #5 clk_i = ~clk_i;

  // Settings and state of the bucket as the block should hold them.
  logic        throttle_on = 1'b0;
  logic [19:0] refill_rate = 20'd100;
  logic [15:0] bucket_burst = 16'd16;
  logic [31:0] event_spacing = 32'd60000000;
  logic [63:0] bucket_micro = 64'd16000000;
  logic [47:0] refill_stamp = '0;
  logic [47:0] wait_stamp = '0;
  logic [47:0] event_stamp = '0;
  logic        event_seen = 1'b0;
  logic [63:0] grants_seen = '0;
  logic [63:0] blocked_grants = '0;
  logic [62:0] wait_sum_us = '0;
  logic [31:0] blocked_window = '0;
  logic [47:0] wait_window_us = '0;

  attempt_result_t predicted_results[$];
  attempt_result_t oldest_result;
  int unsigned     fail_count = 0;
  int unsigned     quiet_cycles = 0;
  int unsigned     stall_left = 0;
  logic            stalls_on = 1'b1;
  logic            gaps_on = 1'b1;
  logic            last_grant;
  logic [47:0]     clock_us = '0;

  function automatic void predict_attempt(cmd_e cmd, logic [47:0] stamp, logic critical);
    attempt_result_t r;
    logic [63:0] cap, elapsed, level, waited, since_event, ms;
    r = '0;
    r.granted = 1'b1;
    if (throttle_on) begin
      cap = 64'(bucket_burst) * MicroTokens;
      if (critical) begin
        bucket_micro = '0;
      end else if (refill_rate != '0) begin
        elapsed = (stamp > refill_stamp) ? 64'(stamp - refill_stamp) : 64'd0;
        if (elapsed >= FillElapse) level = cap;
        else level = bucket_micro + 64'(refill_rate) * elapsed;
        bucket_micro = (level > cap) ? cap : level;
      end
      refill_stamp = stamp;
      if (bucket_micro >= MicroTokens) begin
        bucket_micro = bucket_micro - MicroTokens;
        grants_seen = grants_seen + 64'd1;
        if (cmd == CmdRetry) begin
          waited = (stamp > wait_stamp) ? 64'(stamp - wait_stamp) : 64'd0;
          blocked_grants = blocked_grants + 64'd1;
          if (waited > WaitSumMax - 64'(wait_sum_us)) wait_sum_us = '1;
          else wait_sum_us = 63'(64'(wait_sum_us) + waited);
          if (blocked_window != '1) blocked_window = blocked_window + 32'd1;
          if (waited > WaitWindowMax - 64'(wait_window_us)) wait_window_us = '1;
          else wait_window_us = 48'(64'(wait_window_us) + waited);
          since_event = (stamp > event_stamp) ? 64'(stamp - event_stamp) : 64'd0;
          if (blocked_window != '0 && (!event_seen || since_event >= 64'(event_spacing)))
          begin
            ms = 64'(wait_window_us) / 64'd1000;
            r.event_fire = 1'b1;
            r.event_blocked = blocked_window;
            r.event_wait_ms = (ms > MsMax) ? '1 : ms[31:0];
            event_stamp = stamp;
            event_seen = 1'b1;
            blocked_window = '0;
            wait_window_us = '0;
          end
        end
      end else begin
        r.granted = 1'b0;
        if (cmd == CmdFirst) wait_stamp = stamp;
      end
    end
    r.tokens_level = bucket_micro[35:0];
    r.acquired_total = grants_seen;
    r.blocked_total = blocked_grants;
    r.wait_total_us = wait_sum_us;
    last_grant = r.granted;
    predicted_results.push_back(r);
  endfunction

  function automatic int unsigned pick_idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item, with valid
  // still high so that a following item can go out without a gap.
  task automatic send_attempt(input cmd_e cmd, input logic [47:0] stamp, input logic critical);
    int unsigned gap;
    gap = (gaps_on && $urandom_range(0, 99) >= 55) ? pick_idle_len() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    now_us_i <= stamp;
    disk_critical_i <= critical;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_attempt(cmd, stamp, critical);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (predicted_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Only while the block is idle.
  task automatic write_register(input cfg_reg_e idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegEnable: begin
        throttle_on = data[0];
        bucket_micro = 64'(bucket_burst) * MicroTokens;
      end
      RegRate: refill_rate = data[19:0];
      RegBurst: begin
        bucket_burst = data[15:0];
        bucket_micro = 64'(bucket_burst) * MicroTokens;
      end
      default: event_spacing = data;
    endcase
    @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic en, input logic [19:0] rate,
                                input logic [15:0] burst, input logic [31:0] spacing);
    settle();
    write_register(RegRate, 32'(rate));
    write_register(RegInterval, spacing);
    write_register(RegBurst, 32'(burst));
    write_register(RegEnable, 32'(en));
  endtask

  task automatic test_disabled_grants();
    send_attempt(CmdTry, 48'd0, 1'b0);
    send_attempt(CmdRetry, LastStamp, 1'b1);
    send_attempt(CmdFirst, 48'd12345, 1'b1);
  endtask

  // Starts on the reset rate, burst and interval; later writes burst and rate too.
  task automatic test_edge_cases();
    settle();
    write_register(RegEnable, 32'd1);
    send_attempt(CmdTry, 48'd0, 1'b0);
    send_attempt(CmdFirst, 48'd10, 1'b1);
    send_attempt(CmdRetry, 48'd5010, 1'b0);
    send_attempt(CmdRetry, 48'd20010, 1'b0);
    send_attempt(CmdRetry, 48'd20020, 1'b0);
    // Time going backwards gives no refill.
    send_attempt(CmdTry, 48'd100, 1'b0);
    send_attempt(CmdFirst, 48'd30000, 1'b1);
    settle();
    write_register(RegBurst, 32'd16);
    // A grant on a retry older than its first attempt waits zero.
    send_attempt(CmdRetry, 48'd20000, 1'b0);
    send_attempt(CmdTryAlias, 48'h100_0000_0000, 1'b0);
    send_attempt(CmdFirst, LastStamp, 1'b0);
    send_attempt(CmdRetry, LastStamp, 1'b0);
    // With no refill one token goes and nothing comes back.
    settle();
    write_register(RegBurst, 32'd1);
    write_register(RegRate, 32'd0);
    send_attempt(CmdTry, 48'd1000, 1'b0);
    send_attempt(CmdTry, 48'h8000_0000_0000, 1'b0);
    settle();
    write_register(RegBurst, 32'd0);
    send_attempt(CmdTry, 48'd10, 1'b0);
    send_attempt(CmdRetry, LastStamp, 1'b0);
  endtask

  // The waiting window saturates and then shows up, once the spacing allows an event.
  task automatic test_counter_limits();
    settle();
    write_register(RegRate, 32'd1000000);
    write_register(RegBurst, 32'd65535);
    write_register(RegInterval, 32'd0);
    send_attempt(CmdFirst, 48'd0, 1'b1);
    send_attempt(CmdRetry, LastStamp, 1'b0);
    send_attempt(CmdRetry, LastStamp, 1'b0);
    settle();
    write_register(RegInterval, 32'hFFFF_FFFF);
    send_attempt(CmdRetry, LastStamp, 1'b0);
    send_attempt(CmdRetry, LastStamp, 1'b0);
    settle();
    write_register(RegInterval, 32'd0);
    send_attempt(CmdRetry, LastStamp, 1'b0);
  endtask

  task automatic advance_clock(input int unsigned period);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3) clock_us = clock_us - 48'($urandom_range(1, period + 1));
    else if (r < 5) clock_us = clock_us + 48'(FillElapse) + 48'($urandom);
    else if (r < 8) clock_us = {16'($urandom), 32'($urandom)};
    else if (r < 12) clock_us = clock_us + 48'($urandom);
    else clock_us = clock_us + 48'($urandom_range(0, 2 * period));
  endtask

  task automatic run_traffic(input logic en, input logic [19:0] rate,
                             input logic [15:0] burst, input logic [31:0] spacing);
    int unsigned sent, period, r, tries;
    apply_settings(en, rate, burst, spacing);
    period = (rate == '0) ? 1000 : 1000000 / rate;
    sent = 0;
    while (sent < ItemsPerPhase) begin
      if (sent % 25 < 2) begin
        gaps_on = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        // Blocking acquire: a first attempt, then retries until a grant or eight retries.
        advance_clock(period);
        send_attempt(CmdFirst, clock_us, $urandom_range(0, 19) == 0);
        sent++;
        tries = 0;
        while (!last_grant && tries < 8) begin
          advance_clock(period);
          send_attempt(CmdRetry, clock_us, $urandom_range(0, 19) == 0);
          sent++;
          tries++;
        end
      end else if (r < 90) begin
        advance_clock(period);
        send_attempt(($urandom_range(0, 3) == 0) ? CmdTryAlias : CmdTry, clock_us,
                     $urandom_range(0, 19) == 0);
        sent++;
      end else begin
        send_attempt(cmd_e'($urandom_range(0, 3)), {16'($urandom), 32'($urandom)},
                     1'($urandom));
        sent++;
      end
    end
  endtask

  task automatic test_random_traffic();
    clock_us = 48'd1000;
    run_traffic(1'b1, 20'd100, 16'd16, 32'd60000000);
    run_traffic(1'b1, 20'd1000000, 16'd65535, 32'hFFFF_FFFF);
    run_traffic(1'b1, 20'd1, 16'd1, 32'd1);
    run_traffic(1'b1, 20'($urandom_range(1, 1000000)), 16'($urandom_range(1, 8)),
                $urandom_range(0, 2000000));
    run_traffic(1'b0, 20'($urandom_range(1, 1000000)), 16'($urandom_range(1, 65535)),
                $urandom);
    run_traffic(1'b1, 20'($urandom_range(1, 1000000)), 16'($urandom_range(1, 65535)),
                32'd0);
    run_traffic(1'b1, 20'($urandom_range(1, 1000000)), 16'($urandom_range(1, 65535)),
                $urandom);
    run_traffic(1'b1, 20'd500, 16'd3, 32'd50000);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (predicted_results.size() == 0) begin
        $error("result item with no attempt outstanding");
        fail_count++;
      end else begin
        oldest_result = predicted_results.pop_front();
        compare_field("granted", 64'(oldest_result.granted), 64'(granted_o));
        compare_field("tokens_level", 64'(oldest_result.tokens_level), 64'(tokens_level_o));
        compare_field("acquired_total", oldest_result.acquired_total, acquired_total_o);
        compare_field("blocked_total", oldest_result.blocked_total, blocked_total_o);
        compare_field("wait_total_us", 64'(oldest_result.wait_total_us),
                      64'(wait_total_us_o));
        compare_field("event_fire", 64'(oldest_result.event_fire), 64'(event_fire_o));
        compare_field("event_blocked", 64'(oldest_result.event_blocked),
                      64'(event_blocked_o));
        compare_field("event_wait_ms", 64'(oldest_result.event_wait_ms),
                      64'(event_wait_ms_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (stalls_on && $urandom_range(0, 99) < 25) begin
      out_stall_i <= 1'b1;
      stall_left <= pick_idle_len() - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WatchdogLimit) begin
      $display("tb_token_bucket_rate_limiter_core failed");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_disabled_grants();
    test_edge_cases();
    test_counter_limits();
    test_random_traffic();
    settle();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb_token_bucket_rate_limiter_core passed");
    end else begin
      $display("tb_token_bucket_rate_limiter_core failed");
    end
    $finish;
  end

endmodule
